/* src/scr_pkg.sv */
// ============================================================================
// Scaler register calculator package
// Shared types, register indexes and coefficient tables.
// ============================================================================
package scr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IN_PPL   = 3'd0,
        CFG_IN_LPF   = 3'd1,
        CFG_H_OFFSET = 3'd2,
        CFG_V_OFFSET = 3'd3,
        CFG_MIRROR   = 3'd4,
        CFG_SOURCE   = 3'd5,
        CFG_SYNC     = 3'd6
    } t_cfg_idx;

    // field modes
    localparam logic [1:0] MODE_BOTH   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;

    // divider jobs, in sequence order
    typedef enum logic [2:0] {
        DIV_V_LPI,
        DIV_V_Q,
        DIV_V_TEN,
        DIV_V_ACL,
        DIV_H_PSC,
        DIV_H_SCI
    } t_div_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_WAIT,
        ST_SRCH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    srch_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic v_err;
        logic h_err;
        logic lpi;
        logic srch_more;
        logic div_done;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [9:0]  in_ppl;
        logic [8:0]  in_lpf;
        logic [11:0] h_offset;
        logic [11:0] v_offset;
        logic        mirror;
        logic [1:0]  source;
        logic        sync;
    } t_cfg;

    localparam logic [9:0]  LIM_NORMAL   = 10'd768;
    localparam logic [9:0]  LIM_MIRROR   = 10'd384;
    localparam logic [20:0] XSCI_UNITY   = 21'h400;
    localparam logic [15:0] CY_INTERP    = 16'h00FF;

    localparam logic [8:0] H_ATT_STEPS [8] = '{9'd1, 9'd2, 9'd4, 9'd8,
                                               9'd2, 9'd4, 9'd8, 9'd16};
    localparam logic [8:0] V_ATT_STEPS [8] = '{9'd2, 9'd4, 9'd8, 9'd16,
                                               9'd32, 9'd64, 9'd128, 9'd256};

    localparam logic [7:0] HC_COEF [64] = '{
        8'h00,8'h02,8'h00,8'h06,8'h02,8'h08,8'h00,8'h1E,8'h0E,8'h26,8'h06,8'h42,
        8'h02,8'h80,8'h00,8'hFE,8'hFE,8'h7E,8'h7E,8'h3E,8'h3E,8'h1E,8'h1E,8'h0E,
        8'h0E,8'h06,8'h06,8'h02,8'h02,8'h00,8'h00,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
        8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,8'hFE,
        8'hFE,8'h7E,8'h7E,8'h3E,8'h3E,8'h1E,8'h1E,8'h0E,8'h0E,8'h06,8'h06,8'h02,
        8'h02,8'h00,8'h00,8'hFE};

    localparam logic [15:0] VC_COEF [64] = '{
        16'h0100,16'h0102,16'h0300,16'h0106,16'h0502,16'h0708,16'h0F00,16'h011E,
        16'h110E,16'h1926,16'h3906,16'h3D42,16'h7D02,16'h7F80,16'hFF00,16'h01FE,
        16'h01FE,16'h817E,16'h817E,16'hC13E,16'hC13E,16'hE11E,16'hE11E,16'hF10E,
        16'hF10E,16'hF906,16'hF906,16'hFD02,16'hFD02,16'hFF00,16'hFF00,16'h01FE,
        16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,
        16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,16'h01FE,
        16'h01FE,16'h817E,16'h817E,16'hC13E,16'hC13E,16'hE11E,16'hE11E,16'hF10E,
        16'hF10E,16'hF906,16'hF906,16'hFD02,16'hFD02,16'hFF00,16'hFF00,16'h01FE};

    function automatic logic [7:0] hc_wsum(input logic [5:0] k);
        logic [7:0] w;
        case (k)
            6'd0:                         w = 8'd2;
            6'd1, 6'd2:                   w = 8'd4;
            6'd7, 6'd15, 6'd31, 6'd63:    w = 8'd16;
            default:                      w = 8'd8;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] vc_wsum(input logic [5:0] k);
        logic [7:0] w;
        if (k == 6'd0)       w = 8'd2;
        else if (k < 6'd3)   w = 8'd4;
        else if (k < 6'd7)   w = 8'd8;
        else if (k < 6'd15)  w = 8'd16;
        else if (k < 6'd31)  w = 8'd32;
        else if (k < 6'd63)  w = 8'd64;
        else                 w = 8'd128;
        return w;
    endfunction

    // first step index whose value reaches w; 8 when none does
    function automatic logic [3:0] att_code(input logic [8:0] steps [8],
                                            input logic [7:0] w);
        logic [3:0] c;
        logic       found;
        c     = 4'd8;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && steps[i] >= {1'b0, w}) begin
                c     = 4'(i);
                found = 1'b1;
            end
        end
        return c;
    endfunction

endpackage

/* src/scr_div.sv */
// ============================================================================
// Scaler register calculator divider
// Unsigned 32/32 restoring divider, two quotient bits per cycle.
// ============================================================================
module scr_div
    import scr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot
);

    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dvs;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] t1, t2, rem1;
    logic [31:0] quo1;

    always_comb begin
        t1   = {r_rem[31:0], r_quo[31]};
        quo1 = {r_quo[30:0], 1'b0};
        rem1 = t1;
        if (t1 >= {1'b0, r_dvs}) begin
            rem1    = t1 - {1'b0, r_dvs};
            quo1[0] = 1'b1;
        end
        t2    = {rem1[31:0], quo1[31]};
        n_quo = {quo1[30:0], 1'b0};
        n_rem = t2;
        if (t2 >= {1'b0, r_dvs}) begin
            n_rem    = t2 - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy) else $error("stray divider done");

endmodule

/* src/scr_dp.sv */
// ============================================================================
// Scaler register calculator datapath
// Config registers, working registers, divider and word assembly.
// ============================================================================
module scr_dp
    import scr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [11:0]  i_cfg_data,
    input  logic [9:0]   i_out_width,
    input  logic [9:0]   i_out_height,
    input  logic [1:0]   i_field_mode,
    input  t_cmd         i_cmd,
    output t_status      o_status,
    input  logic         i_m_tready,
    output logic         o_m_tvalid,
    output logic [159:0] o_m_tdata,
    output logic [1:0]   o_m_tuser
);

    t_cfg r_cfg;

    logic [9:0]         r_ox;
    logic [10:0]        r_oy;
    logic               r_lpi, r_verr, r_herr;
    logic signed [15:0] r_q;
    logic [31:0]        r_ysci, r_yacl;
    logic [9:0]         r_xpsc;
    logic [20:0]        r_xsci;
    logic [159:0]       r_tdata;
    logic [1:0]         r_tuser;
    logic               r_tvalid;

    logic [9:0]  in_x, in_y;
    logic        n_lpi;
    logic [10:0] n_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{in_ppl: 10'd720, in_lpf: 9'd288, h_offset: '0, v_offset: '0,
                       mirror: 1'b0, source: '0, sync: 1'b0};
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IN_PPL:   r_cfg.in_ppl   <= i_cfg_data[9:0];
                CFG_IN_LPF:   r_cfg.in_lpf   <= i_cfg_data[8:0];
                CFG_H_OFFSET: r_cfg.h_offset <= i_cfg_data;
                CFG_V_OFFSET: r_cfg.v_offset <= i_cfg_data;
                CFG_MIRROR:   r_cfg.mirror   <= i_cfg_data[0];
                CFG_SOURCE:   r_cfg.source   <= i_cfg_data[1:0];
                CFG_SYNC:     r_cfg.sync     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_x = r_cfg.in_ppl;
    assign in_y = {r_cfg.in_lpf, 1'b0};

    // mode decode at load
    always_comb begin
        n_lpi = 1'b0;
        n_oy  = {1'b0, i_out_height};
        case (i_field_mode)
            MODE_BOTH:   n_lpi = {i_out_height, 1'b0} >= {1'b0, in_y};
            MODE_SINGLE: begin
                n_lpi = {i_out_height, 2'b0} >= {2'b0, in_y};
                n_oy  = {i_out_height, 1'b0};
            end
            default: n_lpi = 1'b0;
        endcase
    end

    // ---- divider operands ----
    logic        q_neg;
    logic [10:0] q_mag;
    logic [16:0] t_sum;
    logic [15:0] t_mag;
    logic [9:0]  lim;
    logic [6:0]  xc;
    logic [31:0] dvd, dvs, quo;
    logic        div_done;

    assign q_neg = r_oy >= {1'b0, in_y};
    assign q_mag = q_neg ? (r_oy + 11'd1 - {1'b0, in_y}) : ({1'b0, in_y} - r_oy - 11'd1);
    assign t_sum = {r_q[15], r_q} + 17'd9;
    assign t_mag = t_sum[16] ? 16'(17'd0 - t_sum) : t_sum[15:0];
    assign xc    = (r_xpsc > 10'd64) ? 7'd64 : r_xpsc[6:0];
    assign lim   = r_cfg.mirror ? LIM_MIRROR : LIM_NORMAL;

    always_comb begin
        dvd = '0;
        dvs = '0;
        case (i_cmd.div_op)
            DIV_V_LPI: begin
                dvd = {12'd0, in_y, 10'd0};
                dvs = {20'd0, 12'({1'b0, r_oy} + 12'd1)};
            end
            DIV_V_Q: begin
                dvd = 32'(q_mag) * 32'd10240;
                dvs = {22'd0, in_y};
            end
            DIV_V_TEN: begin
                dvd = {16'd0, t_mag};
                dvs = 32'd10;
            end
            DIV_V_ACL: begin
                dvd = r_ysci;
                dvs = 32'd1024 - r_ysci;
            end
            DIV_H_PSC: begin
                dvd = {22'd0, in_x};
                dvs = {22'd0, r_ox};
            end
            DIV_H_SCI: begin
                dvd = {12'd0, in_x, 10'd0};
                dvs = {15'd0, 17'(r_ox * xc)};
            end
            default: ;
        endcase
    end

    scr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quo)
    );

    // ---- working registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ox   <= i_out_width;
            r_oy   <= n_oy;
            r_lpi  <= n_lpi;
            r_verr <= {1'b0, in_y} < {1'b0, i_out_height};
            r_herr <= i_out_width == 10'd0;
            r_ysci <= '0;
            r_yacl <= '0;
            r_q    <= '0;
            r_xpsc <= 10'd1;
            r_xsci <= '0;
        end else if (i_cmd.srch_step) begin
            r_xpsc <= r_xpsc + 10'd1;
        end else if (div_done) begin
            case (i_cmd.div_op)
                DIV_V_LPI: r_ysci <= ({1'b0, in_y} > r_oy) ? quo - 32'd1024 : '0;
                DIV_V_Q:   r_q <= (in_y == 10'd0) ? 16'sd0 :
                                  (q_neg ? -$signed(quo[15:0]) : $signed(quo[15:0]));
                DIV_V_TEN: r_ysci <= t_sum[16] ? 32'd0 - quo : quo;
                DIV_V_ACL: r_yacl <= (r_ysci < 32'd512) ? '0 : quo;
                DIV_H_PSC: r_xpsc <= (in_x > r_ox) ? quo[9:0] : 10'd1;
                DIV_H_SCI: r_xsci <= (in_x == r_ox && xc == 7'd1) ? XSCI_UNITY
                                     : quo[20:0] + {14'd0, xc};
                default: ;
            endcase
        end
    end

    // ---- word assembly ----
    logic [31:0] ype, ypo, ysum, vs, vg, ctl, hp, hs;
    logic [5:0]  ky, kx;
    logic [15:0] cy;
    logic [3:0]  dcgy, dcgx;
    logic [7:0]  pfuv, cxy;
    logic        xacm;

    always_comb begin
        ysum = r_ysci + 32'd15;
        if (r_lpi) begin
            ype = {4'd0, r_ysci[31:4]};
            ypo = ype + {6'd0, r_ysci[31:6]};
        end else begin
            ype = {4'd0, ysum[31:4]};
            ypo = ype;
        end
        ky   = (r_yacl < 32'd63) ? r_yacl[5:0] : 6'd63;
        cy   = r_lpi ? CY_INTERP : VC_COEF[ky];
        dcgy = r_lpi ? 4'd0 : att_code(V_ATT_STEPS, vc_wsum(ky));
        vs   = {!r_lpi, 31'd0} | (r_ysci << 21) | (r_yacl << 15) | (ypo << 8) | (ype << 1);
        if (r_verr) vs = '0;

        kx   = 6'(xc - 7'd1);
        cxy  = HC_COEF[kx];
        xacm = xc == 7'd1;
        dcgx = xacm ? 4'd0 : att_code(H_ATT_STEPS, hc_wsum(kx));
        if (r_xsci == XSCI_UNITY)  pfuv = 8'h00;
        else if (r_xsci < 21'h600) pfuv = 8'h01;
        else if (r_xsci < 21'h680) pfuv = 8'h11;
        else if (r_xsci < 21'h700) pfuv = 8'h22;
        else                       pfuv = 8'h33;

        vg  = {r_herr ? 8'h00 : pfuv, r_verr ? 24'd0 : {4'd0, dcgy, cy}};
        ctl = {r_cfg.source, r_cfg.mirror & !r_herr, r_cfg.sync, 4'd0,
               r_cfg.v_offset, 12'd0};
        hp  = r_herr ? '0 : {1'b0, dcgx, 3'd0, kx, xacm, 1'b0, cxy, cxy};
        hs  = r_herr ? {20'd0, r_cfg.h_offset}
                     : {(r_xsci == XSCI_UNITY) | r_xsci[19], r_xsci[18:0], r_cfg.h_offset};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_tdata <= {hs, hp, ctl, vg, vs};
            r_tuser <= {r_verr, r_herr};
        end
    end

    assign o_m_tvalid = r_tvalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    assign o_status = '{v_err: r_verr, h_err: r_herr, lpi: r_lpi,
                        srch_more: {10'd0, in_x} >= 20'(lim * r_xpsc),
                        div_done: div_done, out_free: !r_tvalid || i_m_tready};

endmodule

/* src/scr_ctrl.sv */
// ============================================================================
// Scaler register calculator controller
// Sequences divider jobs, the prescale search and the result load.
// ============================================================================
module scr_ctrl
    import scr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state  r_state, n_state;
    t_div_op r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= DIV_V_LPI;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '{load: 1'b0, div_start: 1'b0, div_op: r_op,
                    srch_step: 1'b0, out_load: 1'b0};
        o_ready = r_state == ST_IDLE;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_START;
                end
            end
            ST_START: begin
                if (!i_status.v_err) begin
                    n_op    = i_status.lpi ? DIV_V_LPI : DIV_V_Q;
                    n_state = ST_DIV;
                end else if (!i_status.h_err) begin
                    n_op    = DIV_H_PSC;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.div_done) begin
                    case (r_op)
                        DIV_V_Q:   begin n_op = DIV_V_TEN; n_state = ST_DIV; end
                        DIV_V_TEN: begin n_op = DIV_V_ACL; n_state = ST_DIV; end
                        DIV_H_PSC: n_state = ST_SRCH;
                        DIV_H_SCI: n_state = ST_OUT;
                        default: begin
                            // vertical done
                            if (!i_status.h_err) begin
                                n_op    = DIV_H_PSC;
                                n_state = ST_DIV;
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (i_status.srch_more) begin
                    o_cmd.srch_step = 1'b1;
                end else begin
                    n_op    = DIV_H_SCI;
                    n_state = ST_DIV;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_wait_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> ($past(r_state) == ST_DIV || $past(r_state) == ST_WAIT))
        else $error("wait entered without divider start");
    a_step_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.srch_step |-> r_op == DIV_H_PSC)
        else $error("prescale step outside search");

endmodule

/* src/scaler_register_calc.sv */
// ============================================================================
// Scaler register calculator
// Computes the five scaler register words from a requested output window.
// ============================================================================
// Each divider job runs 16 radix-4 steps in the shared divider; an item runs
// up to five divider jobs and a prescale search. Throughput: one item at a
// time; next input is taken once the result is in the output register.
// i_rst_n is synchronous active low: control clears and config registers
// return to 720 pixels, 288 lines, offsets and codes zero.
module scaler_register_calc
    import scr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [11:0]  i_cfg_data,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,   // [9:0] out_width, [19:10] out_height, zero pad
    input  logic [1:0]   i_s_tuser,   // [1:0] field_mode
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [159:0] o_m_tdata,   // v_scale, v_gain, control, h_prescale, h_scale
    output logic [1:0]   o_m_tuser    // [0] h_error, [1] v_error
);

    t_cmd    cmd;
    t_status status;

    // config writes are always taken; software writes only while idle
    assign o_cfg_ready = 1'b1;

    scr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    scr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_width  (i_s_tdata[9:0]),
        .i_out_height (i_s_tdata[19:10]),
        .i_field_mode (i_s_tuser),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    // an accepted transfer closes the input until the result is loaded
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second item accepted while busy");
    // vertical error leaves the vertical scale word clear
    a_verr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[31:0] == 32'd0))
        else $error("vertical word set on error");
    // horizontal error leaves the prescale word clear
    a_herr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[127:96] == 32'd0))
        else $error("prescale word set on error");

endmodule

/* tb/testbench.sv */
// ============================================================================
// Scaler register calculator testbench
// Sends output window requests over the input stream and programs the setup
// registers between phases. A built-in predictor computes the five register
// words and error flags, and each result transfer is checked against them.
// ============================================================================
module testbench;
    import scr_pkg::*;

    // register index that no register decodes; writes to it must be dropped
    localparam logic [2:0] CFG_NONE = 3'd7;
    localparam logic [1:0] MODE_ODD = 2'd3;   // decodes like mode two
    localparam int QUIET_LIMIT = 5000;
    localparam int DIR_ROWS = 16;

    typedef struct packed {
        logic [31:0] vs;
        logic [31:0] vg;
        logic [31:0] ctl;
        logic [31:0] hp;
        logic [31:0] hs;
        logic        herr;
        logic        verr;
    } window_regs_t;

    typedef struct packed {
        logic [9:0]   w;
        logic [9:0]   h;
        logic [1:0]   fm;
        logic         typed;
        window_regs_t regs;
    } dir_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [11:0]  i_cfg_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [23:0]  i_s_tdata;
    logic [1:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [159:0] o_m_tdata;
    logic [1:0]   o_m_tuser;

    scaler_register_calc u_dut (.*);

    // shadow copy of the setup registers
    logic [31:0] sh_ppl, sh_lpf, sh_hoff, sh_voff, sh_mirror, sh_src, sh_sync;

    window_regs_t pending_windows[$];
    int  mismatches = 0;
    int  quiet_cycles = 0;
    bit  steady = 0;     // no idling on either side while set

    int unsigned h_steps[8] = '{1, 2, 4, 8, 2, 4, 8, 16};
    int unsigned v_steps[8] = '{2, 4, 8, 16, 32, 64, 128, 256};

    // directed rows; the first two have words read straight off the spec
    // with reset setup: both errors, and a 1:1 window (unity scale)
    dir_row_t dir_table[DIR_ROWS] = '{
        '{10'd0,    10'd1023, MODE_BOTH,   1'b1,
          '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1}},
        '{10'd720,  10'd576,  MODE_BOTH,   1'b1,
          '{32'h0, 32'h0000_00FF, 32'h0, 32'h0002_0000, 32'h8040_0000, 1'b0, 1'b0}},
        '{10'd1,    10'd0,    MODE_BOTH,   1'b0, '0},
        '{10'd1023, 10'd1,    MODE_SINGLE, 1'b0, '0},
        '{10'd1023, 10'd1023, 2'd2,        1'b0, '0},
        '{10'd360,  10'd288,  MODE_SINGLE, 1'b0, '0},
        '{10'd360,  10'd100,  MODE_BOTH,   1'b0, '0},
        '{10'd100,  10'd575,  MODE_BOTH,   1'b0, '0},
        '{10'd720,  10'd576,  2'd2,        1'b0, '0},  // out height equals in
        '{10'd352,  10'd144,  MODE_ODD,    1'b0, '0},
        '{10'd1,    10'd1,    MODE_SINGLE, 1'b0, '0},
        '{10'd512,  10'd288,  2'd2,        1'b0, '0},
        '{10'd64,   10'd10,   2'd2,        1'b0, '0},
        '{10'd11,   10'd400,  MODE_SINGLE, 1'b0, '0},  // doubled past input
        '{10'd300,  10'd200,  MODE_SINGLE, 1'b0, '0},
        '{10'd100,  10'd143,  MODE_SINGLE, 1'b0, '0}
    };

    function automatic logic [31:0] att_level(bit horiz, int unsigned w);
        for (int i = 0; i < 8; i++)
            if ((horiz ? h_steps[i] : v_steps[i]) >= w)
                return i;
        return 8;
    endfunction

    function automatic window_regs_t predict_window(logic [9:0] w, logic [9:0] h,
                                                    logic [1:0] fm);
        int ox, oy, ix, iy, q;
        bit lpi;
        logic [31:0] yacm, ysci, yacl, ypo, ype, dcgy, cy, k, wgt;
        logic [31:0] ux, uox, xpsc, xsci, xim, xacm, dcgx, cxy, pfuv;
        window_regs_t r;
        r  = '0;
        ox = w;
        oy = h;
        ix = sh_ppl;
        iy = sh_lpf * 2;

        // vertical half
        if (iy < oy) begin
            r.verr = 1'b1;
        end else begin
            lpi  = 0;
            yacl = 0;
            dcgy = 0;
            if (fm == MODE_BOTH) begin
                if (2 * oy >= iy) lpi = 1;
            end else if (fm == MODE_SINGLE) begin
                if (4 * oy >= iy) lpi = 1;
                oy = oy * 2;
            end
            if (lpi) begin
                yacm = 0;
                cy   = 32'h00FF;
                if (iy > oy) ysci = (1024 * iy) / (oy + 1) - 1024;
                else ysci = 0;
                ype = ysci / 32'd16;
                ypo = ype + ysci / 32'd64;
            end else begin
                yacm = 1;
                q    = 0;
                // signed, truncating toward zero; may go negative
                if (iy != 0) q = (10240 * (iy - oy - 1)) / iy;
                ysci = (q + 9) / 10;
                ype  = (ysci + 32'd15) / 32'd16;
                ypo  = ype;
                if (ysci < 32'd512) yacl = 0;
                else if (32'd1024 - ysci == 32'd0) yacl = 32'hFFFF_FFFF;
                else yacl = ysci / (32'd1024 - ysci);
                k  = (yacl < 32'd63) ? yacl : 32'd63;
                cy = VC_COEF[k[5:0]];
                if (k == 0) wgt = 2;
                else if (k < 3) wgt = 4;
                else if (k < 7) wgt = 8;
                else if (k < 15) wgt = 16;
                else if (k < 31) wgt = 32;
                else if (k < 63) wgt = 64;
                else wgt = 128;
                dcgy = att_level(1'b0, wgt);
            end
            r.vs = (yacm << 31) | (ysci << 21) | (yacl << 15) | (ypo << 8) | (ype << 1);
            r.vg = (dcgy << 16) | cy;
        end

        // horizontal half
        if (ox == 0) begin
            r.herr = 1'b1;
        end else begin
            ux   = ix;
            uox  = ox;
            xpsc = (ix > ox) ? ux / uox : 32'd1;
            if (sh_mirror[0]) begin
                r.ctl[29] = 1'b1;
                while (ux / xpsc >= 32'd384) xpsc++;
            end else begin
                while (ux / xpsc >= 32'd768) xpsc++;
            end
            if (xpsc > 32'd64) xpsc = 64;
            k   = xpsc - 1;
            cxy = HC_COEF[k[5:0]];
            if (ix == ox && xpsc == 32'd1) xsci = 32'h400;
            else xsci = (32'd1024 * ux) / (uox * xpsc) + xpsc;
            xim = (xsci == 32'h400);
            if (xpsc == 32'd1) begin
                xacm = 1;
                dcgx = 0;
            end else begin
                xacm = 0;
                if (k == 0) wgt = 2;
                else if (k == 1 || k == 2) wgt = 4;
                else if (k == 7 || k == 15 || k == 31 || k == 63) wgt = 16;
                else wgt = 8;
                dcgx = att_level(1'b1, wgt);
            end
            // chroma filter class from the scale increment
            if (xsci == 32'h400) pfuv = 32'h00;
            else if (xsci < 32'h600) pfuv = 32'h01;
            else if (xsci < 32'h680) pfuv = 32'h11;
            else if (xsci < 32'h700) pfuv = 32'h22;
            else pfuv = 32'h33;
            r.vg = (r.vg & 32'h00FF_FFFF) | (pfuv << 24);
            r.hs = (xim << 31) | (xsci << 12);
            r.hp = (dcgx << 27) | ((xpsc - 1) << 18) | (xacm << 17) | (cxy << 8) | cxy;
        end

        r.hs  = (r.hs & ~32'hFFF) | sh_hoff;
        r.ctl = (r.ctl & ~32'h00FF_FFFF) | (sh_voff << 12);
        r.ctl = (r.ctl & ~32'hD000_0000) | (sh_src << 30) | (sh_sync << 28);
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // setup register write; only called with nothing in flight
    task automatic program_reg(logic [2:0] idx, logic [11:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IN_PPL:   sh_ppl    = val[9:0];
            CFG_IN_LPF:   sh_lpf    = val[8:0];
            CFG_H_OFFSET: sh_hoff   = val;
            CFG_V_OFFSET: sh_voff   = val;
            CFG_MIRROR:   sh_mirror = val[0];
            CFG_SOURCE:   sh_src    = val[1:0];
            CFG_SYNC:     sh_sync   = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one window request; valid stays up into the next call when no gap
    task automatic send_window(logic [9:0] w, logic [9:0] h, logic [1:0] fm,
                               bit typed, window_regs_t regs);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, h, w};
        i_s_tuser  <= fm;
        do @(posedge i_clk); while (!o_s_tready);
        pending_windows.push_back(typed ? regs : predict_window(w, h, fm));
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
    endtask

    // result side: random back-pressure
    always @(negedge i_clk)
        i_m_tready <= steady || ($urandom_range(99) >= 32);

    always @(posedge i_clk) begin
        window_regs_t want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[31:0], o_m_tdata[63:32], o_m_tdata[95:64],
                   o_m_tdata[127:96], o_m_tdata[159:128], o_m_tuser[0], o_m_tuser[1]};
            if (pending_windows.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatches++;
            end else begin
                want = pending_windows.pop_front();
                if (got.vs != want.vs) begin
                    $error("v_scale_word exp %h got %h", want.vs, got.vs); mismatches++;
                end
                if (got.vg != want.vg) begin
                    $error("v_gain_word exp %h got %h", want.vg, got.vg); mismatches++;
                end
                if (got.ctl != want.ctl) begin
                    $error("control_word exp %h got %h", want.ctl, got.ctl); mismatches++;
                end
                if (got.hp != want.hp) begin
                    $error("h_prescale_word exp %h got %h", want.hp, got.hp); mismatches++;
                end
                if (got.hs != want.hs) begin
                    $error("h_scale_word exp %h got %h", want.hs, got.hs); mismatches++;
                end
                if (got.herr != want.herr) begin
                    $error("h_error exp %b got %b", want.herr, got.herr); mismatches++;
                end
                if (got.verr != want.verr) begin
                    $error("v_error exp %b got %b", want.verr, got.verr); mismatches++;
                end
            end
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int in_y, hmax;
        logic [9:0] w, h;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        sh_ppl = 720; sh_lpf = 288; sh_hoff = 0; sh_voff = 0;
        sh_mirror = 0; sh_src = 0; sh_sync = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows under reset setup
        for (int i = 0; i < DIR_ROWS; i++)
            send_window(dir_table[i].w, dir_table[i].h, dir_table[i].fm,
                        dir_table[i].typed, dir_table[i].regs);
        drain();

        // phase 1: all maxima; 2: minima; 3: zero sizes; later: random setup
        for (int ph = 1; ph <= 11; ph++) begin
            steady = (ph == 6);
            case (ph)
                1: begin
                    program_reg(CFG_IN_PPL, 12'hFFF);  program_reg(CFG_IN_LPF, 12'hFFF);
                    program_reg(CFG_H_OFFSET, 12'hFFF); program_reg(CFG_V_OFFSET, 12'hFFF);
                    program_reg(CFG_MIRROR, 12'hFFF);  program_reg(CFG_SOURCE, 12'hFFF);
                    program_reg(CFG_SYNC, 12'hFFF);    program_reg(CFG_NONE, 12'hFFF);
                end
                2: begin
                    program_reg(CFG_IN_PPL, 12'd1);    program_reg(CFG_IN_LPF, 12'd1);
                    program_reg(CFG_H_OFFSET, 12'd0);  program_reg(CFG_V_OFFSET, 12'd0);
                    program_reg(CFG_MIRROR, 12'd0);    program_reg(CFG_SOURCE, 12'd0);
                    program_reg(CFG_SYNC, 12'd0);
                end
                3: begin
                    program_reg(CFG_IN_PPL, 12'd0);    program_reg(CFG_IN_LPF, 12'd0);
                    program_reg(CFG_MIRROR, 12'd1);
                end
                default: begin
                    for (int r = 0; r < 8; r++)
                        program_reg(r[2:0], 12'($urandom));
                    // keep most phases near real video sizes
                    if ($urandom_range(2) != 0) begin
                        program_reg(CFG_IN_PPL, 12'($urandom_range(1023, 320)));
                        program_reg(CFG_IN_LPF, 12'($urandom_range(511, 120)));
                    end
                end
            endcase
            in_y = sh_lpf * 2;
            hmax = (in_y > 1023) ? 1023 : in_y;
            for (int n = 0; n < 80; n++) begin
                w = (ph <= 3 && n < 10) ? 10'($urandom_range(1)) : 10'($urandom);
                if ($urandom_range(2) == 0) h = 10'($urandom);
                else h = 10'($urandom_range(hmax));
                send_window(w, h, 2'($urandom), 1'b0, '0);
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
